[src/usbrh_pkg.sv]
// Package for the USB 2.0 root hub request handler.
// Holds the request codes, reply codes, port flag layout and shared structs.
// It depends on nothing else.
package usbrh_pkg;

  localparam logic [7:0] RT_STD_DEV_OUT  = 8'h00;
  localparam logic [7:0] RT_STD_IF_OUT   = 8'h01;
  localparam logic [7:0] RT_STD_EP_OUT   = 8'h02;
  localparam logic [7:0] RT_HUB_OUT      = 8'h20;
  localparam logic [7:0] RT_PORT_OUT     = 8'h23;
  localparam logic [7:0] RT_STD_DEV_IN   = 8'h80;
  localparam logic [7:0] RT_STD_IF_IN    = 8'h81;
  localparam logic [7:0] RT_STD_EP_IN    = 8'h82;
  localparam logic [7:0] RT_HUB_IN       = 8'ha0;
  localparam logic [7:0] RT_PORT_IN      = 8'ha3;

  localparam logic [7:0] RQ_GET_STATUS   = 8'd0;
  localparam logic [7:0] RQ_CLEAR_FEAT   = 8'd1;
  localparam logic [7:0] RQ_SET_FEAT     = 8'd3;
  localparam logic [7:0] RQ_SET_ADDRESS  = 8'd5;
  localparam logic [7:0] RQ_GET_DESC     = 8'd6;
  localparam logic [7:0] RQ_SET_DESC     = 8'd7;
  localparam logic [7:0] RQ_GET_CONFIG   = 8'd8;
  localparam logic [7:0] RQ_SET_CONFIG   = 8'd9;
  localparam logic [7:0] RQ_GET_IFACE    = 8'd10;
  localparam logic [7:0] RQ_SET_IFACE    = 8'd11;
  localparam logic [7:0] RQ_SYNCH_FRAME  = 8'd12;
  localparam logic [7:0] RQ_CLEAR_TT     = 8'd8;
  localparam logic [7:0] RQ_RESET_TT     = 8'd9;
  localparam logic [7:0] RQ_STOP_TT      = 8'd11;

  localparam logic [7:0] DT_DEVICE       = 8'd1;
  localparam logic [7:0] DT_CONFIG       = 8'd2;
  localparam logic [7:0] DT_STRING       = 8'd3;
  localparam logic [7:0] DT_QUALIFIER    = 8'd6;

  localparam logic [15:0] FS_ENABLE      = 16'd1;
  localparam logic [15:0] FS_SUSPEND     = 16'd2;
  localparam logic [15:0] FS_RESET       = 16'd4;
  localparam logic [15:0] FS_POWER       = 16'd8;
  localparam logic [15:0] FS_C_CONNECT   = 16'd16;
  localparam logic [15:0] FS_C_ENABLE    = 16'd17;
  localparam logic [15:0] FS_C_SUSPEND   = 16'd18;
  localparam logic [15:0] FS_C_OVERCUR   = 16'd19;
  localparam logic [15:0] FS_C_RESET     = 16'd20;
  localparam logic [15:0] FS_TEST        = 16'd21;
  localparam logic [15:0] FS_INDICATOR   = 16'd22;

  localparam logic [1:0] SPD_FULL        = 2'd0;
  localparam logic [1:0] SPD_LOW         = 2'd1;
  localparam logic [1:0] SPD_HIGH        = 2'd2;
  localparam logic [1:0] SPD_BAD         = 2'd3;

  localparam logic OP_REQUEST            = 1'b0;
  localparam logic OP_PORT_UPDATE        = 1'b1;

  typedef enum logic [3:0] {
    SRC_NONE      = 4'd0,
    SRC_DEVICE    = 4'd1,
    SRC_QUALIFIER = 4'd2,
    SRC_CONFIG    = 4'd3,
    SRC_LANG      = 4'd4,
    SRC_VENDOR    = 4'd5,
    SRC_PRODUCT   = 4'd6,
    SRC_EMPTY_STR = 4'd7,
    SRC_HUB_DESC  = 4'd8,
    SRC_PORT_STAT = 4'd9,
    SRC_STAT_WORD = 4'd10,
    SRC_ONE_BYTE  = 4'd11
  } src_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic       crst;
    logic       csusp;
    logic       cena;
    logic       cconn;
    logic [1:0] speed;
    logic       susp;
    logic       pwr;
    logic       ena;
    logic       conn;
  } port_flags_t;

  localparam int FLAGS_W = $bits(port_flags_t);

  typedef struct packed {
    logic        opcode;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] req_value;
    logic [15:0] req_index;
    logic        attach;
    logic [1:0]  attach_speed;
  } req_t;

  typedef struct packed {
    logic        stall_res;
    logic [7:0]  reply_length;
    src_t        reply_source;
    logic [15:0] reply_word;
    logic [15:0] change_word;
  } res_t;

  typedef struct packed {
    logic flags_we;
    logic addr_we;
    logic cfg_we;
  } upd_t;

endpackage

[src/usbrh_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the per-port flag store; depends on nothing else.
module usbrh_ram #(
  parameter int WIDTH  = 10,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/usbrh_core.sv]
// Request evaluation for the root hub: decodes one transaction against the
// flags of its port and produces the reply and the state updates.
// Depends on usbrh_pkg.
module usbrh_core #(
  parameter int NUM_PORTS   = 8,
  parameter int MAX_DEVICES = 128
) (
  input  usbrh_pkg::req_t        req,
  input  usbrh_pkg::port_flags_t flags,
  input  logic                   configured,
  output usbrh_pkg::port_flags_t flags_nxt,
  output usbrh_pkg::res_t        res,
  output usbrh_pkg::upd_t        upd
);
  import usbrh_pkg::*;

  localparam logic [7:0] HUB_DESC_LEN = 8'(8 + (NUM_PORTS + 7) / 8);

  logic        port_ok;
  logic        stall;
  logic [7:0]  lo;
  logic [15:0] pstat;
  logic [15:0] pchg;
  logic [1:0]  upd_speed;
  res_t        good;
  upd_t        good_upd;

  assign port_ok = (req.req_index != 16'd0) && (req.req_index <= 16'(NUM_PORTS));
  assign lo      = req.req_value[7:0];

  assign pstat = {5'd0, flags.speed == SPD_HIGH, flags.speed == SPD_LOW, flags.pwr,
                  5'd0, flags.susp, flags.ena, flags.conn};
  assign pchg  = {11'd0, flags.crst, 1'b0, flags.csusp, flags.cena, flags.cconn};

  assign upd_speed = (req.attach_speed == SPD_BAD) ? SPD_FULL : req.attach_speed;

  always_comb begin
    good      = '0;
    good_upd  = '0;
    flags_nxt = flags;
    stall     = 1'b0;
    if (req.opcode == OP_PORT_UPDATE) begin
      if (port_ok) begin
        good_upd.flags_we = 1'b1;
        flags_nxt.speed   = upd_speed;
        flags_nxt.cconn   = 1'b1;
        if (req.attach) begin
          flags_nxt.conn = 1'b1;
        end else begin
          flags_nxt.conn = 1'b0;
          flags_nxt.ena  = 1'b0;
        end
      end
    end else begin
      unique case ({req.request_code, req.request_type})
        {RQ_CLEAR_FEAT, RT_STD_DEV_OUT}, {RQ_CLEAR_FEAT, RT_STD_IF_OUT},
        {RQ_CLEAR_FEAT, RT_STD_EP_OUT}, {RQ_SET_DESC, RT_STD_DEV_OUT},
        {RQ_SET_IFACE, RT_STD_IF_OUT}, {RQ_SYNCH_FRAME, RT_STD_EP_OUT},
        {RQ_CLEAR_FEAT, RT_HUB_OUT}, {RQ_SET_FEAT, RT_HUB_OUT},
        {RQ_CLEAR_TT, RT_PORT_OUT}, {RQ_RESET_TT, RT_PORT_OUT},
        {RQ_STOP_TT, RT_PORT_OUT}: begin
        end
        {RQ_GET_CONFIG, RT_STD_DEV_IN}: begin
          good.reply_length = 8'd1;
          good.reply_source = SRC_ONE_BYTE;
          good.reply_word   = {15'd0, configured};
        end
        {RQ_GET_DESC, RT_STD_DEV_IN}: begin
          unique case (req.req_value[15:8])
            DT_DEVICE: begin
              stall             = (lo != 8'd0);
              good.reply_length = 8'd18;
              good.reply_source = SRC_DEVICE;
            end
            DT_QUALIFIER: begin
              stall             = (lo != 8'd0);
              good.reply_length = 8'd10;
              good.reply_source = SRC_QUALIFIER;
            end
            DT_CONFIG: begin
              stall             = (lo != 8'd0);
              good.reply_length = 8'd25;
              good.reply_source = SRC_CONFIG;
            end
            DT_STRING: begin
              priority if (lo == 8'd0) begin
                good.reply_length = 8'd4;
                good.reply_source = SRC_LANG;
              end else if (lo == 8'd1) begin
                good.reply_length = 8'd16;
                good.reply_source = SRC_VENDOR;
              end else if (lo == 8'd2) begin
                good.reply_length = 8'd32;
                good.reply_source = SRC_PRODUCT;
              end else begin
                good.reply_length = 8'd2;
                good.reply_source = SRC_EMPTY_STR;
              end
            end
            default: stall = 1'b1;
          endcase
        end
        {RQ_GET_IFACE, RT_STD_IF_IN}: begin
          good.reply_length = 8'd1;
          good.reply_source = SRC_ONE_BYTE;
        end
        {RQ_GET_STATUS, RT_STD_DEV_IN}: begin
          good.reply_length = 8'd2;
          good.reply_source = SRC_STAT_WORD;
          good.reply_word   = 16'd1;
        end
        {RQ_GET_STATUS, RT_STD_IF_IN}, {RQ_GET_STATUS, RT_STD_EP_IN},
        {RQ_GET_IFACE, RT_PORT_IN}: begin
          good.reply_length = 8'd2;
          good.reply_source = SRC_STAT_WORD;
        end
        {RQ_SET_ADDRESS, RT_STD_DEV_OUT}: begin
          stall            = ({1'b0, req.req_value} >= 17'(MAX_DEVICES));
          good_upd.addr_we = 1'b1;
        end
        {RQ_SET_CONFIG, RT_STD_DEV_OUT}: begin
          stall           = (req.req_value > 16'd1);
          good_upd.cfg_we = 1'b1;
        end
        {RQ_GET_DESC, RT_HUB_IN}: begin
          stall             = (lo != 8'd0);
          good.reply_length = HUB_DESC_LEN;
          good.reply_source = SRC_HUB_DESC;
        end
        {RQ_GET_STATUS, RT_HUB_IN}: begin
          good.reply_length = 8'd16;
          good.reply_source = SRC_STAT_WORD;
        end
        {RQ_GET_STATUS, RT_PORT_IN}: begin
          stall             = !port_ok;
          good.reply_length = 8'd4;
          good.reply_source = SRC_PORT_STAT;
          good.reply_word   = pstat;
          good.change_word  = pchg;
        end
        {RQ_SET_FEAT, RT_PORT_OUT}: begin
          stall             = !port_ok;
          good_upd.flags_we = 1'b1;
          unique case (req.req_value)
            FS_ENABLE:  flags_nxt.ena  = 1'b1;
            FS_SUSPEND: flags_nxt.susp = 1'b1;
            FS_RESET: begin
              if (flags.conn) begin
                flags_nxt.ena  = 1'b1;
                flags_nxt.crst = 1'b1;
              end
            end
            FS_POWER:   flags_nxt.pwr  = 1'b1;
            FS_TEST, FS_INDICATOR: begin
            end
            default:    stall = 1'b1;
          endcase
        end
        {RQ_CLEAR_FEAT, RT_PORT_OUT}: begin
          stall             = !port_ok;
          good_upd.flags_we = 1'b1;
          unique case (req.req_value)
            FS_ENABLE:    flags_nxt.ena   = 1'b0;
            FS_SUSPEND:   flags_nxt.susp  = 1'b0;
            FS_POWER:     flags_nxt.pwr   = 1'b0;
            FS_C_CONNECT: flags_nxt.cconn = 1'b0;
            FS_C_ENABLE:  flags_nxt.cena  = 1'b0;
            FS_C_SUSPEND: flags_nxt.csusp = 1'b0;
            FS_C_RESET:   flags_nxt.crst  = 1'b0;
            FS_C_OVERCUR, FS_TEST, FS_INDICATOR: begin
            end
            default:      stall = 1'b1;
          endcase
        end
        default: stall = 1'b1;
      endcase
    end
  end

  always_comb begin
    if (stall) begin
      res           = '0;
      res.stall_res = 1'b1;
      upd           = '0;
    end else begin
      res = good;
      upd = good_upd;
    end
  end

endmodule

[src/usb_root_hub_request_handler_top.sv]
// Top level of the USB 2.0 root hub request handler.
// Holds the handshake control, the port flag RAM and the device state.
// Depends on usbrh_pkg, usbrh_ram and usbrh_core.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   opcode, request, wValue, wIndex, attach
//   out_     output     out_valid/out_stall stall_res, length, source, words
//
// A transaction first reads the port flag RAM, then evaluates, writes the flags
// back and loads the output register.
// The next transaction is accepted in the cycle after the result is loaded.
// Reset clears all port flags through per-port valid bits.
// A stalled result holds the block in its evaluate step.
module usb_root_hub_request_handler_top #(
  parameter int NUM_PORTS   = 8,
  parameter int MAX_DEVICES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_request_type,
  input  logic [7:0]  in_request_code,
  input  logic [15:0] in_req_value,
  input  logic [15:0] in_req_index,
  input  logic        in_attach,
  input  logic [1:0]  in_attach_speed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_stall_res,
  output logic [7:0]  out_reply_length,
  output logic [3:0]  out_reply_source,
  output logic [15:0] out_reply_word,
  output logic [15:0] out_change_word
);
  import usbrh_pkg::*;

  localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  state_t         state_r, state_nxt;
  req_t           req_r;
  logic [AW-1:0]  addr_r;
  logic [15:0]    idx_m1;
  logic           in_range;
  logic           accept;
  logic           done;
  logic [NUM_PORTS-1:0] vld_r;
  logic           rd_vld_r;
  logic [FLAGS_W-1:0] rd_data;
  port_flags_t    flags;
  port_flags_t    flags_nxt;
  res_t           res;
  upd_t           upd;
  res_t           out_r;
  logic           out_valid_r, out_valid_nxt;
  logic [6:0]     device_address_r;
  logic           configured_r;

  assign idx_m1   = in_req_index - 16'd1;
  assign in_range = (in_req_index != 16'd0) && (in_req_index <= 16'(NUM_PORTS));
  assign accept   = in_valid && !in_stall;
  assign flags    = rd_vld_r ? port_flags_t'(rd_data) : port_flags_t'('0);

  usbrh_ram #(
    .WIDTH  (FLAGS_W),
    .DEPTH  (NUM_PORTS),
    .ADDR_W (AW)
  ) u_flags_ram (
    .clk     (clk),
    .wr_en   (done && upd.flags_we),
    .wr_addr (addr_r),
    .wr_data (FLAGS_W'(flags_nxt)),
    .rd_en   (accept),
    .rd_addr (idx_m1[AW-1:0]),
    .rd_data (rd_data)
  );

  usbrh_core #(
    .NUM_PORTS   (NUM_PORTS),
    .MAX_DEVICES (MAX_DEVICES)
  ) u_core (
    .req        (req_r),
    .flags      (flags),
    .configured (configured_r),
    .flags_nxt  (flags_nxt),
    .res        (res),
    .upd        (upd)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: if (done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    done     = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    priority if (done) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      out_valid_r      <= 1'b0;
      vld_r            <= '0;
      device_address_r <= 7'd0;
      configured_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (done && upd.flags_we) begin
        vld_r[addr_r] <= 1'b1;
      end
      if (done && upd.addr_we) begin
        device_address_r <= req_r.req_value[6:0];
      end
      if (done && upd.cfg_we) begin
        configured_r <= req_r.req_value[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= '{opcode: in_opcode, request_type: in_request_type,
                    request_code: in_request_code, req_value: in_req_value,
                    req_index: in_req_index, attach: in_attach,
                    attach_speed: in_attach_speed};
      addr_r   <= idx_m1[AW-1:0];
      rd_vld_r <= in_range && vld_r[idx_m1[AW-1:0]];
    end
    if (done) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_stall_res    = out_r.stall_res;
  assign out_reply_length = out_r.reply_length;
  assign out_reply_source = out_r.reply_source;
  assign out_reply_word   = out_r.reply_word;
  assign out_change_word  = out_r.change_word;

endmodule
